@@ design/svc_pkg.sv @@
// svc_pkg: shared types and constants for the sensor value conditioner.
// Register indexes, controller states, command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package svc_pkg;

    localparam int IDX_W = 3;
    localparam int VAL_W = 32;
    localparam int GAIN_W = 16;
    localparam int CNT_W = 16;
    localparam int WRAP_W = 34;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int NUM_W = 49;
    localparam int DEN_W = 32;
    localparam int ITER_W = $clog2(NUM_W + 1);
    localparam int OUT_DATA_W = 136;

    localparam logic signed [VAL_W-1:0] DEFAULT_VALUE_C = 32'sd0;

    localparam logic [IDX_W-1:0] REG_GAIN          = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET        = 3'd1;
    localparam logic [IDX_W-1:0] REG_MIN_ALLOWED   = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_ALLOWED   = 3'd3;
    localparam logic [IDX_W-1:0] REG_AVERAGE_COUNT = 3'd4;
    localparam logic [IDX_W-1:0] REG_ALARM_LOW     = 3'd5;
    localparam logic [IDX_W-1:0] REG_ALARM_HIGH    = 3'd6;
    localparam logic [IDX_W-1:0] REG_MODE_FLAGS    = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MUL_GAIN,
        ST_LIMIT,
        ST_WRAP_GO,
        ST_WRAP_WAIT,
        ST_WRAP_FIX,
        ST_DECIDE,
        ST_FIRST,
        ST_MUL_AVG,
        ST_AVG_PREP,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_UPDATE,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic clear;
        logic mul_gain;
        logic limit;
        logic div_start;
        logic wrap_fix;
        logic first;
        logic mul_avg;
        logic avg_prep;
        logic update;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic is_clear;
        logic wrap_needed;
        logic div_done;
        logic primed;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

@@ design/svc_div.sv @@
// svc_div: iterative restoring divider, one quotient bit per cycle.
// Depends on svc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svc_div
    import svc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    output logic                   done,
    output logic [NUM_W-1:0]       quo,
    output logic [DEN_W-1:0]       rem
);

    logic              busy_reg, busy_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        diff      = trial - {1'b0, den};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ITER_W'(NUM_W);
            quo_next  = num;
            rem_next  = '0;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, den})
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

@@ design/svc_datapath.sv @@
// svc_datapath: configuration registers, shared multiplier, limiter, wrap
// and average arithmetic, state and output register. Depends on svc_pkg, svc_div.
`timescale 1ns / 1ps
`default_nettype none
module svc_datapath
    import svc_pkg::*;
#(
    parameter logic signed [VAL_W-1:0] DEFAULT_VALUE = DEFAULT_VALUE_C
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    input  wire logic                  in_mode,
    input  wire logic [VAL_W-1:0]      in_sample,
    input  wire logic                  cfg_we,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [VAL_W-1:0]      cfg_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_DATA_W-1:0]      out_data
);

    logic signed [GAIN_W-1:0] gain_reg;
    logic signed [VAL_W-1:0]  offset_reg, lo_reg, hi_reg, al_low_reg, al_high_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [1:0]               flags_reg;

    logic                     clear_reg;
    logic signed [VAL_W-1:0]  sample_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  val_reg;
    logic                     wrap_low_reg, wrap_need_reg, neg_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DEN_W-1:0]         den_reg;
    logic signed [WRAP_W-1:0] wrap_reg;
    logic                     changed_reg;

    logic signed [VAL_W-1:0]  avg_reg, min_reg, max_reg;
    logic                     primed_reg, alarm_reg;

    logic                     out_valid_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;

    logic                     div_done;
    logic [NUM_W-1:0]         div_quo;
    logic [DEN_W-1:0]         div_rem;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [CNT_W-1:0]          n_eff;

    assign n_eff = (n_reg == '0) ? CNT_W'(1) : n_reg;

    always_comb
    begin
        if (cmd.mul_avg)
        begin
            mul_a = MUL_A_W'(avg_reg);
            mul_b = $signed({1'b0, n_eff - 1'b1});
        end
        else
        begin
            mul_a = MUL_A_W'(sample_reg) + MUL_A_W'(offset_reg);
            mul_b = MUL_B_W'(gain_reg);
        end
        mul_p = mul_a * mul_b;
    end

    // limiter
    logic signed [PROD_W-1:0] sh;
    logic signed [VAL_W-1:0]  sat_v;
    logic signed [VAL_W:0]    span;
    logic                     circ;
    logic                     use_wrap;

    assign circ = flags_reg[0];
    assign span = (VAL_W+1)'(hi_reg) - (VAL_W+1)'(lo_reg);
    assign use_wrap = circ && (span > 0);

    always_comb
    begin
        sh = prod_reg >>> 8;
        if (&sh[PROD_W-1:VAL_W-1] || ~|sh[PROD_W-1:VAL_W-1])
            sat_v = sh[VAL_W-1:0];
        else if (sh[PROD_W-1])
            sat_v = {1'b1, {(VAL_W-1){1'b0}}};
        else
            sat_v = {1'b0, {(VAL_W-1){1'b1}}};
    end

    // wrap correction
    logic [WRAP_W-1:0]        k_u;
    logic                     rz;
    logic signed [VAL_W:0]    wrap_val;

    always_comb
    begin
        rz  = (div_rem == '0);
        k_u = rz ? div_quo[WRAP_W-1:0] : div_quo[WRAP_W-1:0] + 1'b1;
        if (wrap_low_reg)
            wrap_val = rz ? (VAL_W+1)'(lo_reg)
                          : (VAL_W+1)'(lo_reg) + span - $signed({1'b0, div_rem});
        else
            wrap_val = rz ? (VAL_W+1)'(hi_reg)
                          : (VAL_W+1)'(hi_reg) - span + $signed({1'b0, div_rem});
    end

    // average
    logic signed [PROD_W-1:0] avg_sum;
    logic [PROD_W-1:0]        avg_mag;
    logic signed [VAL_W-1:0]  nv;
    logic                     al_on;

    always_comb
    begin
        avg_sum = prod_reg + PROD_W'(val_reg);
        avg_mag = avg_sum[PROD_W-1] ? PROD_W'(-avg_sum) : PROD_W'(avg_sum);
        nv = neg_reg ? VAL_W'(-div_quo[VAL_W-1:0]) : div_quo[VAL_W-1:0];
        if (circ && (al_high_reg < al_low_reg))
            al_on = (nv >= al_high_reg) && (nv < al_low_reg);
        else
            al_on = (nv >= al_high_reg) || (nv < al_low_reg);
    end

    svc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= 16'sd256;
            offset_reg  <= '0;
            lo_reg      <= {1'b1, {(VAL_W-1){1'b0}}};
            hi_reg      <= {1'b0, {(VAL_W-1){1'b1}}};
            n_reg       <= CNT_W'(1);
            al_low_reg  <= {1'b1, {(VAL_W-1){1'b0}}};
            al_high_reg <= {1'b0, {(VAL_W-1){1'b1}}};
            flags_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN:          gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_OFFSET:        offset_reg  <= cfg_data;
                REG_MIN_ALLOWED:   lo_reg      <= cfg_data;
                REG_MAX_ALLOWED:   hi_reg      <= cfg_data;
                REG_AVERAGE_COUNT: n_reg       <= cfg_data[CNT_W-1:0];
                REG_ALARM_LOW:     al_low_reg  <= cfg_data;
                REG_ALARM_HIGH:    al_high_reg <= cfg_data;
                REG_MODE_FLAGS:    flags_reg   <= cfg_data[1:0];
                default:           flags_reg   <= flags_reg;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            clear_reg   <= in_mode;
            sample_reg  <= in_sample;
            wrap_reg    <= '0;
            changed_reg <= 1'b0;
        end
        if (cmd.mul_gain || cmd.mul_avg)
            prod_reg <= mul_p;
        if (cmd.limit)
        begin
            wrap_need_reg <= 1'b0;
            wrap_low_reg  <= 1'b0;
            num_reg       <= '0;
            den_reg       <= span[DEN_W-1:0];
            val_reg       <= sat_v;
            if (use_wrap)
            begin
                if (sat_v < lo_reg)
                begin
                    wrap_need_reg <= 1'b1;
                    wrap_low_reg  <= 1'b1;
                    num_reg <= NUM_W'((VAL_W+1)'(lo_reg) - (VAL_W+1)'(sat_v));
                end
                else if (sat_v > hi_reg)
                begin
                    wrap_need_reg <= 1'b1;
                    num_reg <= NUM_W'((VAL_W+1)'(sat_v) - (VAL_W+1)'(hi_reg));
                end
            end
            else if (sat_v <= lo_reg)
                val_reg <= lo_reg;
            else if (sat_v >= hi_reg)
                val_reg <= hi_reg;
        end
        if (cmd.wrap_fix)
        begin
            val_reg  <= wrap_val[VAL_W-1:0];
            wrap_reg <= wrap_low_reg ? WRAP_W'(-k_u) : WRAP_W'(k_u);
        end
        if (cmd.avg_prep)
        begin
            neg_reg <= avg_sum[PROD_W-1];
            num_reg <= avg_mag[NUM_W-1:0];
            den_reg <= DEN_W'(n_eff);
        end
        if (cmd.clear)
            changed_reg <= (avg_reg != DEFAULT_VALUE);
        if (cmd.first)
            changed_reg <= (avg_reg != val_reg);
        if (cmd.update)
            changed_reg <= (nv != avg_reg);
    end

    // conditioner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg    <= DEFAULT_VALUE;
            min_reg    <= DEFAULT_VALUE;
            max_reg    <= DEFAULT_VALUE;
            primed_reg <= 1'b0;
            alarm_reg  <= 1'b0;
        end
        else if (cmd.clear)
        begin
            avg_reg    <= DEFAULT_VALUE;
            min_reg    <= DEFAULT_VALUE;
            max_reg    <= DEFAULT_VALUE;
            primed_reg <= 1'b0;
            alarm_reg  <= 1'b0;
        end
        else if (cmd.first)
        begin
            avg_reg    <= val_reg;
            min_reg    <= val_reg;
            max_reg    <= val_reg;
            primed_reg <= 1'b1;
        end
        else if (cmd.update)
        begin
            if (nv != avg_reg)
            begin
                avg_reg <= nv;
                if (flags_reg[1])
                    alarm_reg <= al_on;
            end
            if (val_reg < min_reg)
                min_reg <= val_reg;
            if (val_reg > max_reg)
                max_reg <= val_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
            out_data_reg <= {4'b0000, changed_reg, alarm_reg, wrap_reg,
                             max_reg, min_reg, avg_reg};
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        status.is_clear    = clear_reg;
        status.wrap_needed = wrap_need_reg;
        status.div_done    = div_done;
        status.primed      = primed_reg;
        status.out_free    = !out_valid_reg || out_ready;
    end

endmodule
`default_nettype wire

@@ design/svc_ctrl.sv @@
// svc_ctrl: sequencing state machine for one item at a time.
// Depends on svc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svc_ctrl
    import svc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_MUL_GAIN;
            ST_MUL_GAIN:  state_next = status.is_clear ? ST_CLEAR : ST_LIMIT;
            ST_CLEAR:     state_next = ST_PUBLISH;
            ST_LIMIT:     state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (status.wrap_needed)
                    state_next = ST_WRAP_GO;
                else if (status.primed)
                    state_next = ST_MUL_AVG;
                else
                    state_next = ST_FIRST;
            end
            ST_WRAP_GO:   state_next = ST_WRAP_WAIT;
            ST_WRAP_WAIT: if (status.div_done) state_next = ST_WRAP_FIX;
            ST_WRAP_FIX:  state_next = status.primed ? ST_MUL_AVG : ST_FIRST;
            ST_FIRST:     state_next = ST_PUBLISH;
            ST_MUL_AVG:   state_next = ST_AVG_PREP;
            ST_AVG_PREP:  state_next = ST_AVG_GO;
            ST_AVG_GO:    state_next = ST_AVG_WAIT;
            ST_AVG_WAIT:  if (status.div_done) state_next = ST_UPDATE;
            ST_UPDATE:    state_next = ST_PUBLISH;
            ST_PUBLISH:   if (status.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_MUL_GAIN:  cmd.mul_gain  = 1'b1;
            ST_CLEAR:     cmd.clear     = 1'b1;
            ST_LIMIT:     cmd.limit     = 1'b1;
            ST_WRAP_GO:   cmd.div_start = 1'b1;
            ST_WRAP_FIX:  cmd.wrap_fix  = 1'b1;
            ST_FIRST:     cmd.first     = 1'b1;
            ST_MUL_AVG:   cmd.mul_avg   = 1'b1;
            ST_AVG_PREP:  cmd.avg_prep  = 1'b1;
            ST_AVG_GO:    cmd.div_start = 1'b1;
            ST_UPDATE:    cmd.update    = 1'b1;
            ST_PUBLISH:   cmd.publish   = status.out_free;
            default:      cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ design/sensor_value_conditioner.sv @@
// sensor_value_conditioner: top level, joins controller and datapath.
// Depends on svc_pkg, svc_ctrl, svc_datapath.
//
//  channel  ports                           beat contents
//  s_       s_tvalid s_tready s_tdata s_tuser   one reading or clear
//  m_       m_tvalid m_tready m_tdata           one conditioned result
//  cfg_     cfg_valid cfg_ready cfg_index cfg_data  one register write
//
// The 49-step shared divider runs once for the average and once for a wrap.
// Reset restores register defaults and empties the output register; the
// result holds on m_tdata while m_tready is low, and a new beat is taken
// while an earlier result still waits.
`timescale 1ns / 1ps
`default_nettype none
module sensor_value_conditioner
    import svc_pkg::*;
#(
    parameter logic signed [VAL_W-1:0] DEFAULT_VALUE = DEFAULT_VALUE_C
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // sample
    input  wire logic                  s_tuser,   // mode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // level, lowest, highest, wrap_count, alarm, level_changed, zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [VAL_W-1:0]      cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    svc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    svc_datapath #(
        .DEFAULT_VALUE (DEFAULT_VALUE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_mode   (s_tuser),
        .in_sample (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
`default_nettype wire
